### hw/rtl/jste_pkg.sv
package jste_pkg;

	// one job as held in a queue cell or in the cpu registers
	typedef struct packed {
		logic [15:0] rem;
		logic [31:0] wait_t;
		logic [31:0] turn;
	} entry_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_INS,
		OP_POP,
		OP_AGE,
		OP_POPAGE
	} cell_op_t;

	// command broadcast to every cell of the queue
	typedef struct packed {
		cell_op_t op;
		logic     sorted;
		entry_t   key;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REQ,
		S_CHK,
		S_SWP,
		S_RUN
	} state_t;

	localparam logic [2:0] MODE_FCFS = 3'd0;
	localparam logic [2:0] MODE_SJF  = 3'd1;
	localparam logic [2:0] MODE_PSJF = 3'd2;
	localparam logic [2:0] MODE_RR   = 3'd3;
	localparam logic [2:0] MODE_RRP  = 3'd4;

	localparam logic [1:0] ST_TICK   = 2'd0;
	localparam logic [1:0] ST_DONE   = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_SLICE = 2'd1;
	localparam logic [1:0] REG_PRIO  = 2'd2;
	localparam logic [1:0] REG_SWT   = 2'd3;

	localparam logic ACT_TICK = 1'b0;

	function automatic logic [31:0] inc32(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic entry_t age(input entry_t e);
		entry_t r;
		r = e;
		r.wait_t = inc32(e.wait_t);
		r.turn = inc32(e.turn);
		return r;
	endfunction

endpackage

### hw/rtl/jste_cell.sv
module jste_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  jste_pkg::cell_ctl_t ctl,
	input  jste_pkg::entry_t   left_ent,
	input  logic               left_vld,
	input  jste_pkg::entry_t   right_ent,
	input  logic               right_vld,
	input  logic               found_in,
	output logic               found_out,
	output jste_pkg::entry_t   ent,
	output logic               vld
);
	import jste_pkg::*;

	entry_t ent_q;
	logic   vld_q;
	entry_t ent_nxt;
	logic   vld_nxt;
	logic   match;

	// insert point: first free cell, or first cell with a longer job when sorted
	assign match = !vld_q || (ctl.sorted && (ent_q.rem > ctl.key.rem));
	assign found_out = found_in || match;

	always_comb begin
		ent_nxt = ent_q;
		vld_nxt = vld_q;
		case (ctl.op) inside
			OP_INS: begin
				if (found_in) begin
					ent_nxt = left_ent;
					vld_nxt = left_vld;
				end else if (match) begin
					ent_nxt = ctl.key;
					vld_nxt = 1'b1;
				end
			end
			OP_POP, OP_POPAGE: begin
				ent_nxt = right_ent;
				vld_nxt = right_vld;
			end
			default: ;
		endcase
		if ((ctl.op == OP_AGE || ctl.op == OP_POPAGE) && vld_nxt) begin
			ent_nxt = age(ent_nxt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_nxt;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_nxt;
	end

	assign ent = ent_q;
	assign vld = vld_q;

endmodule

### hw/rtl/job_scheduler_tick_engine_top.sv
// channel  | handshake            | payload
// ---------+----------------------+----------------------------------------------
// command  | start / busy         | action, burst
// result   | done (1-cycle pulse) | status, waiting_time, turnaround_time,
//          |                      | total_time, idle_time
// config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// An arrival inserts without leaving idle; a rejected arrival shows its result
// the cycle after. A tick walks requeue, preempt check, optional swap and run
// steps (swap only on a preemption); each shifts the cell chain at most once.
// Reset clears all valid bits and counters at once; no clearing pass.
// The result is a single-cycle pulse; the receiver cannot stall it.
module job_scheduler_tick_engine_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [15:0] burst,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] waiting_time,
	output logic [31:0] turnaround_time,
	output logic [31:0] total_time,
	output logic [31:0] idle_time,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import jste_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// configuration registers
	logic [2:0]  mode_q;
	logic [15:0] slice_q;
	logic [15:0] prio_q;
	logic [7:0]  swt_q;

	// scheduler state
	state_t      state_q, state_nxt;
	entry_t      cpu_q, tmp_q;
	logic        cpu_busy_q, requeue_q, arrived_q;
	logic [15:0] run_q, slice_act_q;
	logic [7:0]  sw_cnt_q;
	logic [31:0] elapsed_q, idle_q;
	logic [CW-1:0] cnt_q;

	// result registers
	logic        done_q;
	logic [1:0]  status_q;
	logic [31:0] wt_q, tt_q, tot_q, idl_q;

	// cell chain
	cell_ctl_t   ctl;
	entry_t      c_ent [QUEUE_DEPTH];
	logic        c_vld [QUEUE_DEPTH];
	logic        c_fnd [QUEUE_DEPTH];

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			entry_t l_ent, r_ent;
			logic   l_vld, r_vld, f_in;
			if (gi == 0) begin : g_first
				assign l_ent = '0;
				assign l_vld = 1'b0;
				assign f_in = 1'b0;
			end else begin : g_mid
				assign l_ent = c_ent[gi-1];
				assign l_vld = c_vld[gi-1];
				assign f_in = c_fnd[gi-1];
			end
			if (gi == QUEUE_DEPTH - 1) begin : g_last
				assign r_ent = '0;
				assign r_vld = 1'b0;
			end else begin : g_inner
				assign r_ent = c_ent[gi+1];
				assign r_vld = c_vld[gi+1];
			end
			jste_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.left_ent  (l_ent),
				.left_vld  (l_vld),
				.right_ent (r_ent),
				.right_vld (r_vld),
				.found_in  (f_in),
				.found_out (c_fnd[gi]),
				.ent       (c_ent[gi]),
				.vld       (c_vld[gi])
			);
		end
	endgenerate

	// decoded mode and command checks
	logic [2:0]  mode;
	logic        rr, sjf, held, accept, reject, preempt;
	logic        dispatch, switching, run_busy, complete, expire;
	entry_t      cur;
	logic [15:0] cur_run, cur_slice, new_rem, new_run;
	logic [31:0] new_turn, new_idle, new_elapsed;

	assign mode = (mode_q > MODE_RRP) ? MODE_FCFS : mode_q;
	assign rr = (mode == MODE_RR) || (mode == MODE_RRP);
	assign sjf = (mode == MODE_SJF) || (mode == MODE_PSJF);
	assign held = cpu_busy_q || requeue_q;
	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign reject = (burst == 16'd0) || ((cnt_q + CW'(held)) >= CW'(QUEUE_DEPTH));
	assign preempt = (mode == MODE_PSJF) && arrived_q && cpu_busy_q && (cnt_q != '0)
		&& (cpu_q.rem > c_ent[0].rem);

	// run step of a tick
	assign switching = !cpu_busy_q && (cnt_q != '0) && rr && (sw_cnt_q < swt_q);
	assign dispatch = !cpu_busy_q && (cnt_q != '0) && !switching;
	assign run_busy = cpu_busy_q || dispatch;
	assign cur = dispatch ? c_ent[0] : cpu_q;
	assign cur_run = dispatch ? 16'd0 : run_q;
	assign cur_slice = !dispatch ? slice_act_q
		: ((mode == MODE_RRP) && (c_ent[0].rem <= prio_q)) ? c_ent[0].rem : slice_q;
	assign new_rem = (cur.rem != 16'd0) ? cur.rem - 16'd1 : cur.rem;
	assign new_turn = inc32(cur.turn);
	assign new_run = (cur_run != 16'hFFFF) ? cur_run + 16'd1 : cur_run;
	assign complete = (new_rem == 16'd0);
	assign expire = !complete && rr && (new_run >= cur_slice);
	assign new_elapsed = inc32(elapsed_q);
	assign new_idle = run_busy ? idle_q : inc32(idle_q);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: if (accept && action == ACT_TICK) state_nxt = S_REQ;
			S_REQ:  state_nxt = S_CHK;
			S_CHK:  state_nxt = preempt ? S_SWP : S_RUN;
			S_SWP:  state_nxt = S_RUN;
			S_RUN:  state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// cell command
	always_comb begin
		ctl = '{op: OP_NOP, sorted: 1'b0, key: '0};
		unique case (state_q)
			S_IDLE: begin
				if (accept && action != ACT_TICK && !reject) begin
					ctl.op = OP_INS;
					ctl.sorted = sjf;
					ctl.key = '{rem: burst, wait_t: 32'd0, turn: 32'd0};
				end
			end
			S_REQ: begin
				if (requeue_q) begin
					ctl.op = OP_INS;
					ctl.key = cpu_q;
				end
			end
			S_CHK: if (preempt) ctl.op = OP_POP;
			S_SWP: begin
				ctl.op = OP_INS;
				ctl.sorted = 1'b1;
				ctl.key = cpu_q;
			end
			S_RUN: begin
				if (cpu_busy_q || switching) ctl.op = OP_AGE;
				else if (dispatch) ctl.op = OP_POPAGE;
			end
			default: ;
		endcase
	end

	// config port
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FCFS;
			slice_q <= 16'd1;
			prio_q <= 16'd0;
			swt_q <= 8'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE:  mode_q <= cfg_data[2:0];
				REG_SLICE: slice_q <= cfg_data;
				REG_PRIO:  prio_q <= cfg_data;
				REG_SWT:   swt_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// scheduler control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cpu_q <= '0;
			tmp_q <= '0;
			cpu_busy_q <= 1'b0;
			requeue_q <= 1'b0;
			arrived_q <= 1'b0;
			run_q <= 16'd0;
			slice_act_q <= 16'd0;
			sw_cnt_q <= 8'd0;
			elapsed_q <= 32'd0;
			idle_q <= 32'd0;
			cnt_q <= '0;
			done_q <= 1'b0;
			status_q <= ST_TICK;
			wt_q <= 32'd0;
			tt_q <= 32'd0;
			tot_q <= 32'd0;
			idl_q <= 32'd0;
		end else begin
			state_q <= state_nxt;
			done_q <= 1'b0;
			if (ctl.op == OP_INS) cnt_q <= cnt_q + CW'(1);
			else if (ctl.op == OP_POP || ctl.op == OP_POPAGE) cnt_q <= cnt_q - CW'(1);
			unique case (state_q)
				S_IDLE: begin
					if (accept && action != ACT_TICK) begin
						if (reject) begin
							done_q <= 1'b1;
							status_q <= ST_REJECT;
							wt_q <= 32'd0;
							tt_q <= 32'd0;
							tot_q <= elapsed_q;
							idl_q <= idle_q;
						end else begin
							arrived_q <= 1'b1;
						end
					end
				end
				S_REQ: requeue_q <= 1'b0;
				S_CHK: if (preempt) tmp_q <= c_ent[0];
				S_SWP: cpu_q <= tmp_q;
				S_RUN: begin
					arrived_q <= 1'b0;
					elapsed_q <= new_elapsed;
					idle_q <= new_idle;
					if (switching) sw_cnt_q <= sw_cnt_q + 8'd1;
					if (dispatch) begin
						sw_cnt_q <= 8'd0;
						slice_act_q <= cur_slice;
					end
					done_q <= 1'b1;
					status_q <= ST_TICK;
					wt_q <= 32'd0;
					tt_q <= 32'd0;
					tot_q <= new_elapsed;
					idl_q <= new_idle;
					if (run_busy) begin
						run_q <= new_run;
						cpu_q.rem <= new_rem;
						cpu_q.wait_t <= cur.wait_t;
						cpu_q.turn <= new_turn;
						cpu_busy_q <= !complete && !expire;
						requeue_q <= expire;
						if (complete) begin
							status_q <= ST_DONE;
							wt_q <= cur.wait_t;
							tt_q <= new_turn;
							cpu_q.wait_t <= 32'd0;
							cpu_q.turn <= 32'd0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign waiting_time = wt_q;
	assign turnaround_time = tt_q;
	assign total_time = tot_q;
	assign idle_time = idl_q;

`ifndef SYNTH
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |=> state_q == S_IDLE)
		else $error("run step not followed by idle");
	a_held_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cpu_busy_q && requeue_q))
		else $error("job both running and awaiting requeue");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q + CW'(held)) <= CW'(QUEUE_DEPTH))
		else $error("queue over capacity");
	a_head: assert property (@(posedge clk) disable iff (!arst_n)
		c_vld[0] == (cnt_q != '0))
		else $error("head valid disagrees with count");
`endif

endmodule
